[sv/vwi_pkg.sv]
// Shared types, register codes, constants and arithmetic helpers of the
// velocity waypoint integrator. Depends on nothing.
package vwi_pkg;

   localparam int SLOTS   = 5;  // horizon registers in the register map
   localparam int WIDX_W  = 3;
   localparam int HSTEP_W = 7;

   localparam logic [2:0] CSR_STEP_TIME = 3'd0;
   localparam logic [2:0] CSR_INV_SCALE = 3'd1;
   localparam logic [2:0] CSR_HCOUNT    = 3'd2;
   localparam logic [2:0] CSR_HSTEP0    = 3'd3;
   localparam logic [2:0] CSR_HSTEP4    = 3'd7;

   localparam logic [15:0] STEP_TIME_RST = 16'd1311;
   localparam logic [15:0] INV_SCALE_RST = 16'd256;

   // Radians to binary turns (2^32 per turn) and the CORDIC start value 1/K in Q2.30.
   localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_TURN,
      OP_TLATCH,
      OP_SNAP,
      OP_CORD,
      OP_CVX,
      OP_SVY,
      OP_SVX,
      OP_CVY,
      OP_RXDT,
      OP_RYDT,
      OP_ADDY,
      OP_OLOAD,
      OP_OX,
      OP_OY,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOTS-1:0]    snap_mask;
      logic [WIDX_W-1:0]   widx;
      logic                last;
      logic [15:0]         step_time;
      logic [15:0]         inv_scale;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic out_full;
   } status_type;

   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[sv/vwi_if.sv]
// Handshake channel interfaces of the velocity waypoint integrator:
// command input, waypoint output and register write. No dependencies.
interface vwi_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] forward_velocity;
   logic signed [15:0] lateral_velocity;
   logic signed [15:0] yaw_rate;
   modport source (output valid, forward_velocity, lateral_velocity, yaw_rate, input ready);
   modport sink   (input valid, forward_velocity, lateral_velocity, yaw_rate, output ready);
endinterface

interface vwi_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         waypoint_index;
   logic signed [31:0] waypoint_x;
   logic signed [31:0] waypoint_y;
   logic signed [15:0] heading_cos;
   logic signed [15:0] heading_sin;
   logic               last_waypoint;
   modport source (output valid, waypoint_index, waypoint_x, waypoint_y, heading_cos,
                   heading_sin, last_waypoint, input ready);
   modport sink   (input valid, waypoint_index, waypoint_x, waypoint_y, heading_cos,
                   heading_sin, last_waypoint, output ready);
endinterface

interface vwi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/velocity_waypoint_integrator.sv]
// Top level of the velocity waypoint integrator: sequencer plus datapath.
// Depends on vwi_pkg, vwi_if, vwi_ctrl and vwi_datapath.
//
//   channel  direction  beat contents
//   req_ch   in         forward_velocity, lateral_velocity, yaw_rate
//   rsp_ch   out        waypoint_index, waypoint_x, waypoint_y, heading_cos/sin, last
//   csr_ch   in         register index, write data (always ready)
//
// A command beat runs one Euler step at a time up to the largest horizon, then reads
// out one waypoint at a time, each held while rsp_ch has not taken the one before;
// every step and waypoint waits on the single iterative CORDIC, one rotation step a cycle.
// Reset is synchronous; registers return to their reset values at once, no clearing pass.
// A waypoint sits in an output register, so a stalled rsp_ch holds only the next
// emission, and a new command is accepted while the last waypoint still waits.
module velocity_waypoint_integrator import vwi_pkg::*; #(
   parameter int NUM_HORIZONS      = 5,
   parameter int MAX_HORIZON       = 64,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic      clock,
   input  logic      reset,
   vwi_req_if.sink   req_ch,
   vwi_rsp_if.source rsp_ch,
   vwi_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   // The sequencer owns the registers and walks steps and waypoints.
   vwi_ctrl #(
      .NUM_HORIZONS (NUM_HORIZONS),
      .MAX_HORIZON  (MAX_HORIZON)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath does all arithmetic under the command of the sequencer.
   vwi_datapath #(
      .NUM_HORIZONS      (NUM_HORIZONS),
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .forward_velocity (req_ch.forward_velocity),
      .lateral_velocity (req_ch.lateral_velocity),
      .yaw_rate         (req_ch.yaw_rate),
      .rsp_ch           (rsp_ch)
   );

   // A new waypoint is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> !status.out_full)
      else $error("waypoint emitted over a pending beat");

   // The output only becomes valid right after an emission.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.op == OP_EMIT))
      else $error("output valid without emission");

   // Emitted indexes stay within the horizons that exist.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.waypoint_index < 3'(NUM_HORIZONS))
      else $error("waypoint index out of range");

endmodule

[sv/vwi_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine in Q1.14 of a binary angle.
// Depends on vwi_pkg.
module vwi_cordic import vwi_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [15:0] cos_out,
   output logic signed [15:0] sin_out
);

   localparam int IT_W = $clog2(ITERATIONS);

   typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_FIN} cstate_type;

   cstate_type         state_ff;
   logic [IT_W-1:0]    it_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic               done_ff;
   logic signed [15:0] cos_ff, sin_ff;

   logic               flip_in;
   logic [31:0]        ang_f;
   logic signed [33:0] dx, dy, at;
   logic signed [33:0] x_in, y_in, z_in;

   // Result rounded half up to Q1.14 and clamped to one.
   function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
      logic signed [33:0] r;
      logic signed [15:0] q;
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) begin
         q = 16'sd16384;
      end else if (r < -34'sd16384) begin
         q = -16'sd16384;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

   always_comb begin
      // Second and third quadrants are turned by half a turn and negated at the end.
      flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
      ang_f   = flip_in ? (angle ^ 32'h8000_0000) : angle;
      dx      = y_ff >>> it_ff;
      dy      = x_ff >>> it_ff;
      at      = atan_turn(5'(it_ff));
      if (!z_ff[33]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            CS_IDLE: begin
               if (start) begin
                  x_ff     <= CORDIC_START;
                  y_ff     <= '0;
                  z_ff     <= {{2{ang_f[31]}}, ang_f};
                  flip_ff  <= flip_in;
                  it_ff    <= '0;
                  done_ff  <= 1'b0;
                  state_ff <= CS_RUN;
               end
            end
            CS_RUN: begin
               x_ff  <= x_in;
               y_ff  <= y_in;
               z_ff  <= z_in;
               it_ff <= it_ff + 1'b1;
               if (it_ff == IT_W'(ITERATIONS - 1)) begin
                  state_ff <= CS_FIN;
               end
            end
            CS_FIN: begin
               cos_ff   <= flip_ff ? -to_q14(x_ff) : to_q14(x_ff);
               sin_ff   <= flip_ff ? -to_q14(y_ff) : to_q14(y_ff);
               done_ff  <= 1'b1;
               state_ff <= CS_IDLE;
            end
            default: state_ff <= CS_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

[sv/vwi_datapath.sv]
// Datapath: pose accumulators, snapshot registers, shared multiplier, CORDIC
// and the waypoint output register. Depends on vwi_pkg, vwi_if and vwi_cordic.
module vwi_datapath import vwi_pkg::*; #(
   parameter int NUM_HORIZONS      = 5,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [15:0] forward_velocity,
   input  logic signed [15:0] lateral_velocity,
   input  logic signed [15:0] yaw_rate,
   vwi_rsp_if.source          rsp_ch
);

   localparam int IW = (NUM_HORIZONS > 1) ? $clog2(NUM_HORIZONS) : 1;

   logic signed [15:0] vx_ff, vy_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic [31:0]        head_ff, turn_ff;
   logic signed [65:0] prod_ff;
   logic signed [32:0] acc_ff, rx_ff, ry_ff;
   logic signed [31:0] wx_ff, wy_ff;
   logic signed [31:0] snap_x_ff [NUM_HORIZONS];
   logic signed [31:0] snap_y_ff [NUM_HORIZONS];
   logic [31:0]        snap_h_ff [NUM_HORIZONS];

   logic               out_valid_ff;
   logic [2:0]         out_idx_ff;
   logic signed [31:0] out_x_ff, out_y_ff;
   logic signed [15:0] out_cos_ff, out_sin_ff;
   logic               out_last_ff;

   logic [IW-1:0]      sel;
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [65:0] prod_in;
   logic signed [65:0] sh26, sh28, sh8;
   logic signed [31:0] pos_add_in;
   logic signed [31:0] scaled_in;
   logic               cord_start, cord_done;
   logic [31:0]        cord_angle;
   logic signed [15:0] cos_v, sin_v;

   assign sel        = cmd.widx[IW-1:0];
   assign cord_start = (cmd.op == OP_CORD) || (cmd.op == OP_OLOAD);
   assign cord_angle = (cmd.op == OP_OLOAD) ? snap_h_ff[sel] : head_ff;

   vwi_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (cord_angle),
      .done    (cord_done),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   always_comb begin
      case (cmd.op)
         OP_LOAD:  begin mul_a = 34'(yaw_rate);      mul_b = {16'b0, cmd.step_time}; end
         OP_TURN:  begin mul_a = prod_ff[33:0];      mul_b = TURN_PER_RAD;           end
         OP_CVX:   begin mul_a = 34'(cos_v);         mul_b = 32'(vx_ff);             end
         OP_SVY:   begin mul_a = 34'(sin_v);         mul_b = 32'(vy_ff);             end
         OP_SVX:   begin mul_a = 34'(sin_v);         mul_b = 32'(vx_ff);             end
         OP_CVY:   begin mul_a = 34'(cos_v);         mul_b = 32'(vy_ff);             end
         OP_RXDT:  begin mul_a = 34'(rx_ff);         mul_b = {16'b0, cmd.step_time}; end
         OP_RYDT:  begin mul_a = 34'(ry_ff);         mul_b = {16'b0, cmd.step_time}; end
         OP_OLOAD: begin mul_a = 34'(snap_x_ff[sel]); mul_b = {16'b0, cmd.inv_scale}; end
         OP_OX:    begin mul_a = 34'(snap_y_ff[sel]); mul_b = {16'b0, cmd.inv_scale}; end
         default:  begin mul_a = '0;                 mul_b = '0;                     end
      endcase
      prod_in = mul_a * mul_b;

      // Roundings: half an LSB added, then an arithmetic shift (sh28 is shifted by its bit slice).
      sh26       = (prod_ff + (66'sd1 <<< 25)) >>> 26;
      sh28       = prod_ff + (66'sd1 <<< 27);
      sh8        = (prod_ff + 66'sd128) >>> 8;
      scaled_in  = sat32(48'(sh8));
      pos_add_in = sat32(48'(sh26) + 48'(cmd.op == OP_RYDT ? pos_x_ff : pos_y_ff));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.op)
         OP_LOAD: begin
            vx_ff    <= forward_velocity;
            vy_ff    <= lateral_velocity;
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            head_ff  <= '0;
         end
         OP_TLATCH: turn_ff <= sh28[59:28];
         OP_SNAP: begin
            for (int i = 0; i < NUM_HORIZONS; i++) begin
               if (cmd.snap_mask[i]) begin
                  snap_x_ff[i] <= pos_x_ff;
                  snap_y_ff[i] <= pos_y_ff;
                  snap_h_ff[i] <= head_ff;
               end
            end
         end
         OP_SVY:  acc_ff <= $signed(prod_ff[32:0]);
         OP_SVX:  rx_ff  <= acc_ff - $signed(prod_ff[32:0]);
         OP_CVY:  acc_ff <= $signed(prod_ff[32:0]);
         OP_RXDT: ry_ff  <= acc_ff + $signed(prod_ff[32:0]);
         OP_RYDT: pos_x_ff <= pos_add_in;
         OP_ADDY: begin
            pos_y_ff <= pos_add_in;
            head_ff  <= head_ff + turn_ff;
         end
         OP_OX:   wx_ff <= scaled_in;
         OP_OY:   wy_ff <= scaled_in;
         OP_EMIT: begin
            out_idx_ff  <= cmd.widx;
            out_x_ff    <= wx_ff;
            out_y_ff    <= wy_ff;
            out_cos_ff  <= cos_v;
            out_sin_ff  <= sin_v;
            out_last_ff <= cmd.last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.cordic_done = cord_done;
   assign status.out_full    = out_valid_ff;

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.waypoint_index = out_idx_ff;
   assign rsp_ch.waypoint_x     = out_x_ff;
   assign rsp_ch.waypoint_y     = out_y_ff;
   assign rsp_ch.heading_cos    = out_cos_ff;
   assign rsp_ch.heading_sin    = out_sin_ff;
   assign rsp_ch.last_waypoint  = out_last_ff;

endmodule

[sv/vwi_ctrl.sv]
// Controller: register file and the sequencer that steps the integration and
// the waypoint readout. Depends on vwi_pkg and vwi_if.
module vwi_ctrl import vwi_pkg::*; #(
   parameter int NUM_HORIZONS = 5,
   parameter int MAX_HORIZON  = 64
) (
   input  logic       clock,
   input  logic       reset,
   vwi_csr_if.sink    csr_ch,
   vwi_req_if.sink    req_ch,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int                 HCAP   = (MAX_HORIZON > 127) ? 127 : MAX_HORIZON;
   localparam logic [HSTEP_W-1:0] HCAP_V = HSTEP_W'(HCAP);

   typedef enum logic [4:0] {
      S_IDLE, S_TURN, S_TLATCH, S_SNAP, S_CORD, S_CWAIT,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
      S_OLOAD, S_OX, S_OY, S_OWAIT, S_OEMIT
   } state_type;

   state_type          state_ff;
   logic [HSTEP_W-1:0] step_ff;
   logic [WIDX_W-1:0]  widx_ff;
   logic [15:0]        step_time_ff, inv_scale_ff;
   logic [2:0]         hcount_ff;
   logic [HSTEP_W-1:0] hstep_ff [NUM_HORIZONS];

   logic [2:0]         cnt;
   logic [HSTEP_W-1:0] hz [NUM_HORIZONS];
   logic [HSTEP_W-1:0] max_h;
   logic [SLOTS-1:0]   mask;
   logic [2:0]         hidx;
   logic               accept, last;

   assign csr_ch.ready = 1'b1;
   assign hidx         = csr_ch.index - CSR_HSTEP0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RST;
         inv_scale_ff <= INV_SCALE_RST;
         hcount_ff    <= '0;
         for (int i = 0; i < NUM_HORIZONS; i++) begin
            hstep_ff[i] <= '0;
         end
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index) inside
            CSR_STEP_TIME: step_time_ff <= csr_ch.data;
            CSR_INV_SCALE: inv_scale_ff <= csr_ch.data;
            CSR_HCOUNT:    hcount_ff    <= csr_ch.data[2:0];
            [CSR_HSTEP0:CSR_HSTEP4]: begin
               for (int i = 0; i < NUM_HORIZONS; i++) begin
                  if (hidx == 3'(i)) begin
                     hstep_ff[i] <= csr_ch.data[HSTEP_W-1:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt   = (hcount_ff > 3'(NUM_HORIZONS)) ? 3'(NUM_HORIZONS) : hcount_ff;
      max_h = '0;
      mask  = '0;
      for (int i = 0; i < NUM_HORIZONS; i++) begin
         hz[i] = (hstep_ff[i] > HCAP_V) ? HCAP_V : hstep_ff[i];
         if (3'(i) < cnt) begin
            if (hz[i] > max_h) begin
               max_h = hz[i];
            end
            mask[i] = (hz[i] == step_ff);
         end
      end
      accept = req_ch.valid && (state_ff == S_IDLE);
      last   = (widx_ff == cnt - 3'd1);
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.snap_mask = mask;
      cmd.widx      = widx_ff;
      cmd.last      = last;
      cmd.step_time = step_time_ff;
      cmd.inv_scale = inv_scale_ff;
      unique case (state_ff)
         S_IDLE:   cmd.op = accept ? OP_LOAD : OP_NOP;
         S_TURN:   cmd.op = OP_TURN;
         S_TLATCH: cmd.op = OP_TLATCH;
         S_SNAP:   cmd.op = OP_SNAP;
         S_CORD:   cmd.op = OP_CORD;
         S_M1:     cmd.op = OP_CVX;
         S_M2:     cmd.op = OP_SVY;
         S_M3:     cmd.op = OP_SVX;
         S_M4:     cmd.op = OP_CVY;
         S_M5:     cmd.op = OP_RXDT;
         S_M6:     cmd.op = OP_RYDT;
         S_M7:     cmd.op = OP_ADDY;
         S_OLOAD:  cmd.op = OP_OLOAD;
         S_OX:     cmd.op = OP_OX;
         S_OY:     cmd.op = OP_OY;
         S_OEMIT:  cmd.op = status.out_full ? OP_NOP : OP_EMIT;
         default:  cmd.op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         widx_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  step_ff  <= '0;
                  widx_ff  <= '0;
                  state_ff <= (cnt == 3'd0) ? S_IDLE : S_TURN;
               end
            end
            S_TURN:   state_ff <= S_TLATCH;
            S_TLATCH: state_ff <= S_SNAP;
            S_SNAP:   state_ff <= (step_ff == max_h) ? S_OLOAD : S_CORD;
            S_CORD:   state_ff <= S_CWAIT;
            S_CWAIT: begin
               if (status.cordic_done) begin
                  state_ff <= S_M1;
               end
            end
            S_M1: state_ff <= S_M2;
            S_M2: state_ff <= S_M3;
            S_M3: state_ff <= S_M4;
            S_M4: state_ff <= S_M5;
            S_M5: state_ff <= S_M6;
            S_M6: state_ff <= S_M7;
            S_M7: begin
               step_ff  <= step_ff + 1'b1;
               state_ff <= S_SNAP;
            end
            S_OLOAD: state_ff <= S_OX;
            S_OX:    state_ff <= S_OY;
            S_OY:    state_ff <= S_OWAIT;
            S_OWAIT: begin
               if (status.cordic_done) begin
                  state_ff <= S_OEMIT;
               end
            end
            S_OEMIT: begin
               if (!status.out_full) begin
                  widx_ff  <= widx_ff + 1'b1;
                  state_ff <= last ? S_IDLE : S_OLOAD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
